// ----- rtl/mrts_pkg.sv -----
// Shared types, codes and constants for the MLP router top-k select block.
// The GELU lookup table is built here at elaboration time.
// No dependencies.
`timescale 1ns / 1ps

package mrts_pkg;

    localparam int VAL_W   = 16;
    localparam int ACC_W   = 48;
    localparam int LOGIT_W = 32;
    localparam int ADDR_W  = 15;
    localparam int STORE_LIMIT = 32768;

    typedef logic signed [VAL_W-1:0]   t_val;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [LOGIT_W-1:0] t_logit;

    // Load item targets
    localparam logic [1:0] OP_W1   = 2'd0;
    localparam logic [1:0] OP_W2   = 2'd1;
    localparam logic [1:0] OP_SKIP = 2'd2;
    localparam logic [1:0] OP_FEAT = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FEAT  = 2'd0;
    localparam logic [1:0] CFG_HID   = 2'd1;
    localparam logic [1:0] CFG_EXP   = 2'd2;
    localparam logic [1:0] CFG_TOPK  = 2'd3;

    // What a MAC pass computes; also selects the operand memories
    typedef enum logic [1:0] {
        KIND_HID  = 2'd0,   // first layer row: W1 x features
        KIND_SEC  = 2'd1,   // second layer row: W2 x hidden
        KIND_SKIP = 2'd2    // skip row: Ws x features
    } t_kind;

    typedef struct packed {
        logic  first;
        logic  last;
        t_kind kind;
    } t_mac_tag;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam t_acc FOUR_Q24 = 48'sd67108864;

    typedef logic [255:0][VAL_W-1:0] t_gelu_lut;

    // GELU at bin centers over [-4,4), 1/32 per bin, Q3.12 rounded to nearest.
    // erf from its power series in Q24, evaluated once at elaboration.
    function automatic t_gelu_lut gelu_build();
        t_gelu_lut   lut;
        int          d;
        logic [63:0] m, z2, t, pos, neg, s, x2, q, half, v, r;
        logic        done;
        lut = '0;
        for (int n = 0; n < 256; n++) begin
            d    = 2 * n + 1 - 256;
            m    = 64'((d < 0) ? -d : d);
            z2   = m * m * 64'd2048;
            t    = 64'd16777216;
            pos  = 64'd16777216;
            neg  = 64'd0;
            done = 1'b0;
            for (int k = 1; k < 64; k++) begin
                if (!done) begin
                    t = ((t * z2) >> 24) / 64'(k);
                    if (t == 64'd0) begin
                        done = 1'b1;
                    end else if (k % 2 == 1) begin
                        neg = neg + t / 64'(2 * k + 1);
                    end else begin
                        pos = pos + t / 64'(2 * k + 1);
                    end
                end
            end
            s    = (pos > neg) ? pos - neg : 64'd0;
            x2   = m * m * 64'd4096;
            q    = (((x2 * s) >> 24) * 64'd6693141) >> 24;
            half = m << 17;
            v    = 64'd67108864 + q;
            v    = (d < 0) ? v - half : v + half;
            r    = ((v + 64'd2048) >> 12) - 64'd16384;
            lut[n] = r[VAL_W-1:0];
        end
        return lut;
    endfunction

    localparam t_gelu_lut GELU_LUT = gelu_build();

endpackage

// ----- rtl/mrts_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mrts_ram #(
    parameter int W = 16,
    parameter int D = 256
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                  i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mrts_mac.sv -----
// Multiply-accumulate unit: registered product of Q3.12 operands, 48-bit saturating
// accumulator, GELU of the finished sum. Depends on mrts_pkg.
`timescale 1ns / 1ps

module mrts_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mrts_pkg::t_mac_tag i_tag,
    input  mrts_pkg::t_val    i_a,
    input  mrts_pkg::t_val    i_b,
    output logic              o_valid,
    output mrts_pkg::t_kind   o_kind,
    output mrts_pkg::t_acc    o_acc,
    output mrts_pkg::t_val    o_gelu
);

    logic                     r_p_valid;
    mrts_pkg::t_mac_tag       r_p_tag;
    logic signed [31:0]       r_p;
    mrts_pkg::t_acc           r_acc;
    logic                     r_o_valid;
    mrts_pkg::t_kind          r_o_kind;

    logic signed [mrts_pkg::ACC_W:0] sum;
    mrts_pkg::t_acc           base;
    mrts_pkg::t_acc           n_acc;
    mrts_pkg::t_acc           shifted;
    mrts_pkg::t_acc           rounded;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
        end
        r_p_tag <= i_tag;
        r_p     <= i_a * i_b;
    end

    // saturating accumulate, restarted on the first product of a row
    always_comb begin
        base = r_p_tag.first ? '0 : r_acc;
        sum  = {base[mrts_pkg::ACC_W-1], base} + (mrts_pkg::ACC_W+1)'(r_p);
        if (sum > (mrts_pkg::ACC_W+1)'(mrts_pkg::ACC_MAX)) begin
            n_acc = mrts_pkg::ACC_MAX;
        end else if (sum < $signed({1'b1, mrts_pkg::ACC_MIN})) begin
            n_acc = mrts_pkg::ACC_MIN;
        end else begin
            n_acc = sum[mrts_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_p_valid && r_p_tag.last;
        end
        if (r_p_valid) begin
            r_acc <= n_acc;
        end
        r_o_kind <= r_p_tag.kind;
    end

    // GELU: zero below -4, identity from 4 up, table in between
    always_comb begin
        shifted = r_acc + mrts_pkg::FOUR_Q24;
        rounded = (r_acc + 48'sd2048) >>> 12;
        if (r_acc < -mrts_pkg::FOUR_Q24) begin
            o_gelu = '0;
        end else if (r_acc >= mrts_pkg::FOUR_Q24) begin
            o_gelu = (rounded > 48'sd32767) ? 16'sd32767 : rounded[15:0];
        end else begin
            o_gelu = mrts_pkg::GELU_LUT[shifted[26:19]];
        end
    end

    assign o_valid = r_o_valid;
    assign o_kind  = r_o_kind;
    assign o_acc   = r_acc;

endmodule

// ----- rtl/mlp_router_topk_select_top.sv -----
// Top level of the MLP router with top-k expert selection: load path,
// compute sequencer, logit scan and result register.
// Depends on mrts_pkg, mrts_ram and mrts_mac.
`timescale 1ns / 1ps

// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------------
// input    | i_in_valid   | o_in_stall   | i_op, i_address, i_value, i_last
// result   | o_out_valid  | i_out_stall  | o_expert_index, o_rank, o_last_result
// config   | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// A load item is taken whenever the block is idle. An item with last set runs
// the router: one MAC per cycle through a single multiplier, nh*nf + ne*(nh+nf)
// products plus a pipeline drain, then a scan of the logit memory per reported
// expert. Input is stalled for the whole run; results wait in an output register
// while the result side stalls. Reset is synchronous and needs no clearing pass.

module mlp_router_topk_select_top #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_HIDDEN   = 128,
    parameter int MAX_EXPERTS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [14:0] i_address,
    input  logic signed [15:0] i_value,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_expert_index,
    output logic [5:0]  o_rank,
    output logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);

    localparam int FL_FULL = MAX_HIDDEN * MAX_FEATURES;
    localparam int SL_FULL = MAX_EXPERTS * MAX_HIDDEN;
    localparam int SK_FULL = MAX_EXPERTS * MAX_FEATURES;
    localparam int FL_D = (FL_FULL > mrts_pkg::STORE_LIMIT) ? mrts_pkg::STORE_LIMIT : FL_FULL;
    localparam int SL_D = (SL_FULL > mrts_pkg::STORE_LIMIT) ? mrts_pkg::STORE_LIMIT : SL_FULL;
    localparam int SK_D = (SK_FULL > mrts_pkg::STORE_LIMIT) ? mrts_pkg::STORE_LIMIT : SK_FULL;
    localparam int FL_AW = (FL_D > 1) ? $clog2(FL_D) : 1;
    localparam int SL_AW = (SL_D > 1) ? $clog2(SL_D) : 1;
    localparam int SK_AW = (SK_D > 1) ? $clog2(SK_D) : 1;
    localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int HAW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int EAW = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int FCW = $clog2(MAX_FEATURES + 1);
    localparam int HCW = $clog2(MAX_HIDDEN + 1);
    localparam int ECW = $clog2(MAX_EXPERTS + 1);
    localparam int BW  = $clog2(FL_FULL + SL_FULL + SK_FULL + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_HID, S_HWAIT, S_EXP, S_EWAIT, S_SCAN, S_SDRAIN, S_EMIT
    } t_state;

    t_state             r_state;
    logic [8:0]         r_cfg_feat;
    logic [7:0]         r_cfg_hid;
    logic [6:0]         r_cfg_exp;
    logic [6:0]         r_cfg_topk;

    logic [FCW-1:0]     nf;
    logic [HCW-1:0]     nh;
    logic [ECW-1:0]     ne;
    logic [ECW-1:0]     kk;

    logic [FCW-1:0]     r_i;
    logic [HCW-1:0]     r_j;
    logic [ECW-1:0]     r_e;
    logic               r_seg;
    logic [BW-1:0]      r_base_a;
    logic [BW-1:0]      r_base_b;
    logic [HCW-1:0]     r_wcnt;
    logic [ECW-1:0]     r_lcnt;
    mrts_pkg::t_acc     r_a2;

    logic               r_iss_valid;
    mrts_pkg::t_mac_tag r_iss_tag;
    mrts_pkg::t_mac_tag iss_tag;
    logic               iss_valid;
    logic [BW-1:0]      a_addr;

    logic               r_sc_valid;
    logic [ECW-1:0]     r_sc_idx;
    logic               r_found;
    logic [ECW-1:0]     r_best;
    mrts_pkg::t_logit   r_best_val;
    logic [MAX_EXPERTS-1:0] r_taken;
    logic [ECW-1:0]     r_rank;

    logic               r_out_valid;
    logic [5:0]         r_out_idx;
    logic [5:0]         r_out_rank;
    logic               r_out_last;

    logic               in_xfer;
    logic               out_xfer;
    logic               out_free;
    logic               we_w1, we_w2, we_sk, we_f;

    logic [15:0]        w1_rd, w2_rd, sk_rd, f_rd, h_rd;
    logic [31:0]        l_rd;
    mrts_pkg::t_val     mac_a, mac_b;
    logic               mac_valid;
    mrts_pkg::t_kind    mac_kind;
    mrts_pkg::t_acc     mac_acc;
    mrts_pkg::t_val     mac_gelu;

    logic signed [mrts_pkg::ACC_W:0] lsum;
    mrts_pkg::t_logit   logit;
    logic               we_h, we_l;

    // sizes in use, clipped to the built maxima
    always_comb begin
        nf = (int'(r_cfg_feat) > MAX_FEATURES) ? FCW'(MAX_FEATURES) : FCW'(r_cfg_feat);
        nh = (int'(r_cfg_hid) > MAX_HIDDEN) ? HCW'(MAX_HIDDEN) : HCW'(r_cfg_hid);
        ne = (int'(r_cfg_exp) > MAX_EXPERTS) ? ECW'(MAX_EXPERTS) : ECW'(r_cfg_exp);
        kk = (int'(r_cfg_topk) > int'(ne)) ? ne : ECW'(r_cfg_topk);
    end

    // load path
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign we_w1 = in_xfer && (i_op == mrts_pkg::OP_W1)   && (int'(i_address) < FL_FULL);
    assign we_w2 = in_xfer && (i_op == mrts_pkg::OP_W2)   && (int'(i_address) < SL_FULL);
    assign we_sk = in_xfer && (i_op == mrts_pkg::OP_SKIP) && (int'(i_address) < SK_FULL);
    assign we_f  = in_xfer && (i_op == mrts_pkg::OP_FEAT) && (int'(i_address) < MAX_FEATURES);

    // MAC issue: one weight/operand pair per cycle
    always_comb begin
        iss_valid     = 1'b0;
        iss_tag.first = 1'b0;
        iss_tag.last  = 1'b0;
        iss_tag.kind  = mrts_pkg::KIND_HID;
        a_addr        = r_base_a + BW'(r_i);
        if (r_state == S_HID) begin
            iss_valid     = 1'b1;
            iss_tag.first = (r_i == '0);
            iss_tag.last  = (r_i == nf - FCW'(1));
        end else if (r_state == S_EXP) begin
            iss_valid = 1'b1;
            if (!r_seg) begin
                a_addr        = r_base_a + BW'(r_j);
                iss_tag.first = (r_j == '0);
                iss_tag.last  = (r_j == nh - HCW'(1));
                iss_tag.kind  = mrts_pkg::KIND_SEC;
            end else begin
                a_addr        = r_base_b + BW'(r_i);
                iss_tag.first = (r_i == '0);
                iss_tag.last  = (r_i == nf - FCW'(1));
                iss_tag.kind  = mrts_pkg::KIND_SKIP;
            end
        end
    end

    mrts_ram #(.W(16), .D(FL_D)) u_w1_ram (
        .i_clk(i_clk), .i_we(we_w1), .i_waddr(i_address[FL_AW-1:0]),
        .i_wdata(i_value), .i_raddr(a_addr[FL_AW-1:0]), .o_rdata(w1_rd)
    );
    mrts_ram #(.W(16), .D(SL_D)) u_w2_ram (
        .i_clk(i_clk), .i_we(we_w2), .i_waddr(i_address[SL_AW-1:0]),
        .i_wdata(i_value), .i_raddr(a_addr[SL_AW-1:0]), .o_rdata(w2_rd)
    );
    mrts_ram #(.W(16), .D(SK_D)) u_sk_ram (
        .i_clk(i_clk), .i_we(we_sk), .i_waddr(i_address[SK_AW-1:0]),
        .i_wdata(i_value), .i_raddr(a_addr[SK_AW-1:0]), .o_rdata(sk_rd)
    );
    mrts_ram #(.W(16), .D(MAX_FEATURES)) u_feat_ram (
        .i_clk(i_clk), .i_we(we_f), .i_waddr(i_address[FAW-1:0]),
        .i_wdata(i_value), .i_raddr(r_i[FAW-1:0]), .o_rdata(f_rd)
    );
    mrts_ram #(.W(16), .D(MAX_HIDDEN)) u_hid_ram (
        .i_clk(i_clk), .i_we(we_h), .i_waddr(r_wcnt[HAW-1:0]),
        .i_wdata(mac_gelu), .i_raddr(r_j[HAW-1:0]), .o_rdata(h_rd)
    );
    mrts_ram #(.W(32), .D(MAX_EXPERTS)) u_logit_ram (
        .i_clk(i_clk), .i_we(we_l), .i_waddr(r_lcnt[EAW-1:0]),
        .i_wdata(logit), .i_raddr(r_e[EAW-1:0]), .o_rdata(l_rd)
    );

    // operand select follows the issued pass through its registered tag
    always_comb begin
        unique case (r_iss_tag.kind)
            mrts_pkg::KIND_SEC: begin
                mac_a = w2_rd;
                mac_b = h_rd;
            end
            mrts_pkg::KIND_SKIP: begin
                mac_a = sk_rd;
                mac_b = f_rd;
            end
            default: begin
                mac_a = w1_rd;
                mac_b = f_rd;
            end
        endcase
    end

    mrts_mac u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(r_iss_valid), .i_tag(r_iss_tag), .i_a(mac_a), .i_b(mac_b),
        .o_valid(mac_valid), .o_kind(mac_kind), .o_acc(mac_acc), .o_gelu(mac_gelu)
    );

    // finished rows: hidden values, and logit = second layer + skip, 32-bit sat
    assign we_h = mac_valid && (mac_kind == mrts_pkg::KIND_HID);
    assign we_l = mac_valid && (mac_kind == mrts_pkg::KIND_SKIP);
    always_comb begin
        lsum = {r_a2[mrts_pkg::ACC_W-1], r_a2} + {mac_acc[mrts_pkg::ACC_W-1], mac_acc};
        if (lsum > 49'sh0_7FFF_FFFF) begin
            logit = 32'sh7FFF_FFFF;
        end else if (lsum < -49'sh0_8000_0000) begin
            logit = 32'sh8000_0000;
        end else begin
            logit = lsum[31:0];
        end
    end

    assign out_xfer = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || out_xfer;

    // sequencer, scan and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_feat  <= 9'd256;
            r_cfg_hid   <= 8'd128;
            r_cfg_exp   <= 7'd64;
            r_cfg_topk  <= 7'd8;
            r_iss_valid <= 1'b0;
            r_sc_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_taken     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_e         <= '0;
            r_seg       <= 1'b0;
            r_base_a    <= '0;
            r_base_b    <= '0;
            r_wcnt      <= '0;
            r_lcnt      <= '0;
            r_rank      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mrts_pkg::CFG_FEAT: r_cfg_feat <= i_cfg_data;
                    mrts_pkg::CFG_HID:  r_cfg_hid  <= i_cfg_data[7:0];
                    mrts_pkg::CFG_EXP:  r_cfg_exp  <= i_cfg_data[6:0];
                    default:            r_cfg_topk <= i_cfg_data[6:0];
                endcase
            end

            r_iss_valid <= iss_valid;
            r_iss_tag   <= iss_tag;
            if (we_h) begin
                r_wcnt <= r_wcnt + HCW'(1);
            end
            if (mac_valid && (mac_kind == mrts_pkg::KIND_SEC)) begin
                r_a2 <= mac_acc;
            end
            if (we_l) begin
                r_lcnt <= r_lcnt + ECW'(1);
            end

            // best so far; strictly greater keeps the lower index on ties
            r_sc_valid <= (r_state == S_SCAN);
            r_sc_idx   <= r_e;
            if (r_sc_valid && !r_taken[r_sc_idx[EAW-1:0]]
                && (!r_found || $signed(l_rd) > r_best_val)) begin
                r_found    <= 1'b1;
                r_best     <= r_sc_idx;
                r_best_val <= l_rd;
            end

            if (out_xfer) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_last) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_i      <= '0;
                    r_j      <= '0;
                    r_e      <= '0;
                    r_seg    <= 1'b0;
                    r_base_a <= '0;
                    r_base_b <= '0;
                    r_wcnt   <= '0;
                    r_lcnt   <= '0;
                    if (nf == '0 || nh == '0 || ne == '0 || kk == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_HID;
                    end
                end
                S_HID: begin
                    if (iss_tag.last) begin
                        r_i      <= '0;
                        r_base_a <= r_base_a + BW'(nf);
                        r_j      <= r_j + HCW'(1);
                        if (r_j == nh - HCW'(1)) begin
                            r_state <= S_HWAIT;
                        end
                    end else begin
                        r_i <= r_i + FCW'(1);
                    end
                end
                S_HWAIT: begin
                    r_j      <= '0;
                    r_base_a <= '0;
                    if (r_wcnt == nh) begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (!r_seg) begin
                        if (iss_tag.last) begin
                            r_j      <= '0;
                            r_seg    <= 1'b1;
                            r_base_a <= r_base_a + BW'(nh);
                        end else begin
                            r_j <= r_j + HCW'(1);
                        end
                    end else begin
                        if (iss_tag.last) begin
                            r_i      <= '0;
                            r_seg    <= 1'b0;
                            r_base_b <= r_base_b + BW'(nf);
                            r_e      <= r_e + ECW'(1);
                            if (r_e == ne - ECW'(1)) begin
                                r_state <= S_EWAIT;
                            end
                        end else begin
                            r_i <= r_i + FCW'(1);
                        end
                    end
                end
                S_EWAIT: begin
                    r_e     <= '0;
                    r_rank  <= '0;
                    r_found <= 1'b0;
                    r_taken <= '0;
                    if (r_lcnt == ne) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_e <= r_e + ECW'(1);
                    if (r_e == ne - ECW'(1)) begin
                        r_state <= S_SDRAIN;
                    end
                end
                S_SDRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= 6'(r_best);
                        r_out_rank  <= 6'(r_rank);
                        r_out_last  <= (r_rank == kk - ECW'(1));
                        r_taken[r_best[EAW-1:0]] <= 1'b1;
                        r_found     <= 1'b0;
                        r_e         <= '0;
                        r_rank      <= r_rank + ECW'(1);
                        if (r_rank == kk - ECW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_expert_index = r_out_idx;
    assign o_rank         = r_out_rank;
    assign o_last_result  = r_out_last;

endmodule

// ----- sim/mrts_router_checker.sv -----
// Checker for the MLP router top-k select block: watches the load, config
// and result channels, predicts the ranked experts and compares them.
// Depends on mrts_pkg.
`timescale 1ns / 1ps

module mrts_router_checker #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_HIDDEN   = 128,
    parameter int MAX_EXPERTS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic [14:0] i_address,
    input  logic signed [15:0] i_value,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_expert_index,
    input  logic [5:0]  i_rank,
    input  logic        i_last_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import mrts_pkg::*;

    typedef struct packed {
        logic [5:0] expert;
        logic [5:0] rank;
        logic       last;
    } t_pick;

    localparam int W1_DEPTH   = MAX_HIDDEN * MAX_FEATURES;
    localparam int W2_DEPTH   = MAX_EXPERTS * MAX_HIDDEN;
    localparam int SKIP_DEPTH = MAX_EXPERTS * MAX_FEATURES;

    t_pick  expected_picks[$];
    t_val   w1_mem[W1_DEPTH];
    t_val   w2_mem[W2_DEPTH];
    t_val   skip_mem[SKIP_DEPTH];
    t_val   feat_mem[MAX_FEATURES];
    t_val   hid_mem[MAX_HIDDEN];
    t_logit logit_mem[MAX_EXPERTS];
    t_val   gelu_lut[256];
    logic [8:0] nfeat_reg;
    logic [7:0] nhid_reg;
    logic [6:0] nexp_reg;
    logic [6:0] topk_reg;

    // GELU at the center of each 1/32 bin over [-4,4), erf by power series in Q24
    initial begin
        int          d;
        logic [63:0] m, z2, t, pos, neg, s, x2, q, half, v;
        for (int n = 0; n < 256; n++) begin
            d   = 2 * n + 1 - 256;
            m   = (d < 0) ? 64'(-d) : 64'(d);
            z2  = m * m * 64'd2048;
            t   = 64'd16777216;
            pos = 64'd16777216;
            neg = 64'd0;
            for (int k = 1; k < 64; k++) begin
                t = ((t * z2) >> 24) / 64'(k);
                if (t == 64'd0) break;
                if (k % 2 == 1) neg = neg + t / 64'(2 * k + 1);
                else pos = pos + t / 64'(2 * k + 1);
            end
            s    = (pos > neg) ? pos - neg : 64'd0;
            x2   = m * m * 64'd4096;
            q    = (((x2 * s) >> 24) * 64'd6693141) >> 24;
            half = m << 17;
            v    = 64'd67108864 + q;
            v    = (d < 0) ? v - half : v + half;
            gelu_lut[n] = t_val'(((v + 64'd2048) >> 12) - 64'd16384);
        end
    end

    // 48-bit accumulate with saturation on every add
    function automatic longint acc_step(longint acc, longint prod);
        longint s;
        s = acc + prod;
        if (s > longint'(ACC_MAX)) return longint'(ACC_MAX);
        if (s < longint'(ACC_MIN)) return longint'(ACC_MIN);
        return s;
    endfunction

    function automatic t_val gelu_of(longint a);
        longint r;
        if (a < -longint'(FOUR_Q24)) return '0;
        if (a >= longint'(FOUR_Q24)) begin
            r = (a + 2048) >>> 12;
            return (r > 32767) ? t_val'(32767) : t_val'(r);
        end
        return gelu_lut[((a + longint'(FOUR_Q24)) >>> 19) & 255];
    endfunction

    // Full router pass: hidden layer, logits, then ranked expert picks
    task automatic score_and_rank();
        int     nf, nh, ne, kk, best;
        longint acc, a2, al, s;
        logic   taken[MAX_EXPERTS];
        t_pick  p;
        nf = (nfeat_reg > MAX_FEATURES) ? MAX_FEATURES : int'(nfeat_reg);
        nh = (nhid_reg > MAX_HIDDEN) ? MAX_HIDDEN : int'(nhid_reg);
        ne = (nexp_reg > MAX_EXPERTS) ? MAX_EXPERTS : int'(nexp_reg);
        kk = (topk_reg > ne) ? ne : int'(topk_reg);
        if (nf == 0 || nh == 0 || ne == 0 || kk == 0) return;
        for (int j = 0; j < nh; j++) begin
            acc = 0;
            for (int i = 0; i < nf; i++)
                acc = acc_step(acc, longint'(w1_mem[j*nf+i]) * longint'(feat_mem[i]));
            hid_mem[j] = gelu_of(acc);
        end
        for (int e = 0; e < ne; e++) begin
            a2 = 0;
            al = 0;
            for (int j = 0; j < nh; j++)
                a2 = acc_step(a2, longint'(w2_mem[e*nh+j]) * longint'(hid_mem[j]));
            for (int i = 0; i < nf; i++)
                al = acc_step(al, longint'(skip_mem[e*nf+i]) * longint'(feat_mem[i]));
            s = a2 + al;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            logit_mem[e] = t_logit'(s);
        end
        for (int e = 0; e < MAX_EXPERTS; e++) taken[e] = 1'b0;
        // strict compare keeps the lower index on equal logits
        for (int r = 0; r < kk; r++) begin
            best = -1;
            for (int e = 0; e < ne; e++) begin
                if (!taken[e] && (best < 0 || logit_mem[e] > logit_mem[best])) best = e;
            end
            taken[best] = 1'b1;
            p.expert = 6'(best);
            p.rank   = 6'(r);
            p.last   = (r + 1 == kk);
            expected_picks.push_back(p);
        end
    endtask

    always @(posedge i_clk) begin
        t_pick p;
        if (!i_rst_n) begin
            nfeat_reg = 9'd256;
            nhid_reg  = 8'd128;
            nexp_reg  = 7'd64;
            topk_reg  = 7'd8;
            expected_picks.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FEAT: nfeat_reg = i_cfg_data;
                    CFG_HID:  nhid_reg  = i_cfg_data[7:0];
                    CFG_EXP:  nexp_reg  = i_cfg_data[6:0];
                    CFG_TOPK: topk_reg  = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            // result transfer
            if (i_out_valid && !i_out_stall) begin
                if (expected_picks.size() == 0) begin
                    if (o_errors < 10)
                        $display("tb: unexpected result expert=%0d rank=%0d last=%0b",
                                 i_expert_index, i_rank, i_last_result);
                    o_errors++;
                end else begin
                    p = expected_picks.pop_front();
                    if (p.expert !== i_expert_index || p.rank !== i_rank ||
                        p.last !== i_last_result) begin
                        if (o_errors < 10)
                            $display("tb: mismatch exp e=%0d r=%0d l=%0b got e=%0d r=%0d l=%0b",
                                     p.expert, p.rank, p.last,
                                     i_expert_index, i_rank, i_last_result);
                        o_errors++;
                    end
                end
            end
            // load transfer
            if (i_in_valid && !i_in_stall) begin
                case (i_op)
                    OP_W1:   if (i_address < W1_DEPTH) w1_mem[i_address] = i_value;
                    OP_W2:   if (i_address < W2_DEPTH) w2_mem[i_address] = i_value;
                    OP_SKIP: if (i_address < SKIP_DEPTH) skip_mem[i_address] = i_value;
                    OP_FEAT: if (i_address < MAX_FEATURES) feat_mem[i_address] = i_value;
                    default: ;
                endcase
                if (i_last) score_and_rank();
            end
        end
        o_pending = expected_picks.size();
    end

endmodule

// ----- sim/tb_mlp_router_topk_select_top.sv -----
// Testbench top for the MLP router top-k select block: clock, reset,
// load and config stimulus, result-side stalls and the verdict.
// Depends on mrts_pkg, mlp_router_topk_select_top and mrts_router_checker.
`timescale 1ns / 1ps

module tb_mlp_router_topk_select_top;
    import mrts_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [1:0]  op        = OP_W1;
    logic [14:0] address   = '0;
    logic signed [15:0] value = '0;
    logic        last      = 1'b0;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CFG_FEAT;
    logic [8:0]  cfg_data  = '0;
    logic        in_stall, out_valid, last_result;
    logic [5:0]  expert_index, rank;
    int          errors, pending;

    // stimulus knobs, owned by the main process
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    logic hold_req   = 1'b0;
    int   hold_cnt   = 0;
    int   cycles     = 0;
    int   nf_cfg = 256, nh_cfg = 128, ne_cfg = 64;

    mlp_router_topk_select_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_op(op), .i_address(address), .i_value(value), .i_last(last),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_expert_index(expert_index), .o_rank(rank), .o_last_result(last_result),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    mrts_router_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_address(address), .i_value(value), .i_last(last),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_expert_index(expert_index), .i_rank(rank), .i_last_result(last_result),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: one long hold-off when asked, random stalls otherwise
    always @(negedge clk) begin
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic int eff_feat();
        return (nf_cfg > 256) ? 256 : nf_cfg;
    endfunction
    function automatic int eff_hid();
        return (nh_cfg > 128) ? 128 : nh_cfg;
    endfunction
    function automatic int eff_exp();
        return (ne_cfg > 64) ? 64 : ne_cfg;
    endfunction

    // mostly small magnitudes so GELU lands in its table range
    function automatic logic signed [15:0] pick_value();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2047)) - 16'sd1024;
    endfunction

    // All tasks start and end just after a falling edge.
    // The write enable stays high; the caller drops it after the last write.
    task automatic write_reg(input logic [1:0] idx, input int data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= 9'(data);
        case (idx)
            CFG_FEAT: nf_cfg = data & 511;
            CFG_HID:  nh_cfg = data & 255;
            CFG_EXP:  ne_cfg = data & 127;
            default:  ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_sizes(input int f, input int h, input int e, input int k);
        write_reg(CFG_FEAT, f);
        write_reg(CFG_HID, h);
        write_reg(CFG_EXP, e);
        write_reg(CFG_TOPK, k);
        cfg_we <= 1'b0;
    endtask

    task automatic send(input logic [1:0] o, input int a, input logic signed [15:0] v,
                        input logic l);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        address  <= 15'(a);
        value    <= v;
        last     <= l;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // fill every entry the current sizes read; fill 0 zero, 1 random, 2 extremes
    task automatic load_all(input int fill);
        int nf, nh, ne, total, n;
        logic signed [15:0] v;
        nf = eff_feat();
        nh = eff_hid();
        ne = eff_exp();
        total = nh * nf + ne * nh + ne * nf + nf;
        n = 0;
        for (int s = 0; s < 4; s++) begin
            for (int a = 0; a < ((s == 0) ? nh*nf : (s == 1) ? ne*nh :
                                 (s == 2) ? ne*nf : nf); a++) begin
                n++;
                v = (fill == 0) ? 16'sd0 : (fill == 1) ? pick_value() :
                    ($urandom_range(0, 1) ? 16'sd32767 : -16'sd32768);
                send((s == 0) ? OP_W1 : (s == 1) ? OP_W2 : (s == 2) ? OP_SKIP : OP_FEAT,
                     a, v, n == total);
            end
        end
    endtask

    // an address inside what the current sizes read
    function automatic int addr_in_use(input logic [1:0] o);
        case (o)
            OP_W1:   return $urandom_range(0, eff_hid() * eff_feat() - 1);
            OP_W2:   return $urandom_range(0, eff_exp() * eff_hid() - 1);
            OP_SKIP: return $urandom_range(0, eff_exp() * eff_feat() - 1);
            default: return $urandom_range(0, eff_feat() - 1);
        endcase
    endfunction

    // updates inside the sizes in use plus some noise, then the start item
    task automatic random_run(input int n);
        logic [1:0] o;
        for (int i = 0; i < n; i++) begin
            o = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                send(o, $urandom_range(0, 32767), 16'($urandom), 1'b0);
            else
                send(o, addr_in_use(o), pick_value(), 1'b0);
        end
        o = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 2)) : OP_FEAT;
        send(o, addr_in_use(o), pick_value(), 1'b1);
    endtask

    // wait out every expected result plus the compute time of a silent run
    task automatic settle();
        int nf, nh, ne;
        nf = eff_feat();
        nh = eff_hid();
        ne = eff_exp();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (nh * nf + ne * (nh + nf) + (ne + 2) * 64 + 64) @(negedge clk);
    endtask

    initial begin
        int e_pick;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // equal logits with top_k clipped to the experts in use; this fill
        // covers every entry that the smaller sizes below read
        set_sizes(4, 3, 6, 9);
        load_all(0);
        settle();

        // value extremes, ignored writes, last on a weight item
        send(OP_W2, 0, 16'sd32767, 1'b0);
        send(OP_SKIP, 5, -16'sd32768, 1'b0);
        send(OP_FEAT, 2, 16'sd32767, 1'b0);
        send(OP_W1, 1, -16'sd32768, 1'b0);
        send(OP_FEAT, 15'h7fff, 16'sd1000, 1'b0);
        send(OP_W2, 9000, 16'sd1000, 1'b0);
        send(OP_SKIP, 20000, -16'sd1000, 1'b0);
        send(OP_W1, 15'h7fff, 16'sd32767, 1'b1);
        settle();

        // random phases over the four idling modes
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 27 : 0;
            stall_pct = (ph == 2) ? 63 : (ph == 3) ? 27 : 0;
            e_pick    = $urandom_range(1, 6);
            set_sizes($urandom_range(1, 4), $urandom_range(1, 3), e_pick,
                      $urandom_range(0, e_pick + 2));
            for (int r = 0; r < 2; r++) random_run($urandom_range(4, 6));
            settle();
        end

        // sizes of zero: no results
        set_sizes(2, 2, 3, 0);
        send(OP_FEAT, 0, pick_value(), 1'b1);
        settle();
        set_sizes(2, 2, 0, 3);
        send(OP_FEAT, 1, pick_value(), 1'b1);
        settle();
        set_sizes(0, 2, 3, 3);
        send(OP_W1, 0, pick_value(), 1'b1);
        settle();
        set_sizes(2, 0, 3, 3);
        send(OP_W2, 0, pick_value(), 1'b1);
        settle();

        // long result hold-off while loads keep coming
        idle_pct  = 0;
        stall_pct = 0;
        set_sizes(2, 2, 6, 6);
        hold_req = 1'b1;
        for (int r = 0; r < 3; r++) random_run(3);
        settle();

        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
